// ===== rtl/rfdq_pkg.sv =====
package rfdq_pkg;

    // Default configuration
    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths on the ports
    localparam int MODE_W   = 3;
    localparam int VAL_W    = 32;
    localparam int REMOVE_W = 31;
    localparam int FILL_W   = 7;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_ADD_BACK     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_FRONT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE_BACK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE_FRONT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OUTPUT       = 3'd4;

    // Operations of the shared subtract unit
    typedef enum logic
    {
        OP_ORDER,   // biased last - biased first: range order and span
        OP_STEP     // remaining span - step
    } sub_op_t;

    typedef struct packed
    {
        logic [MODE_W-1:0]       mode;
        logic signed [VAL_W-1:0] first_value;
        logic signed [VAL_W-1:0] step_size;
        logic signed [VAL_W-1:0] last_value;
        logic [REMOVE_W-1:0]     remove_count;
    } cmd_t;

    typedef struct packed
    {
        logic signed [VAL_W-1:0] item_value;
        logic                    last_item;
        logic                    is_empty;
        logic [FILL_W-1:0]       fill_level;
        logic                    dropped_values;
        logic                    step_error;
    } result_t;

endpackage

// ===== rtl/rfdq_sub_unit.sv =====
module rfdq_sub_unit
    import rfdq_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  sub_op_t              op,
    input  logic [WORD_BITS-1:0] first_word,
    input  logic [WORD_BITS-1:0] last_word,
    input  logic [WORD_BITS-1:0] rem_word,
    input  logic [WORD_BITS-1:0] step_word,
    output logic [WORD_BITS-1:0] diff,
    output logic                 borrow
);

    localparam logic [WORD_BITS-1:0] SIGN_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic [WORD_BITS-1:0] opa;
    logic [WORD_BITS-1:0] opb;
    logic [WORD_BITS:0]   wide;

    // Pick operands; flip sign bits so an unsigned subtract orders signed values
    always_comb
    begin
        unique case (op)
            OP_ORDER:
            begin
                opa = last_word ^ SIGN_BIT;
                opb = first_word ^ SIGN_BIT;
            end
            OP_STEP:
            begin
                opa = rem_word;
                opb = step_word;
            end
            default:
            begin
                opa = rem_word;
                opb = step_word;
            end
        endcase
    end

    // Subtract with borrow out
    assign wide   = {1'b0, opa} - {1'b0, opb};
    assign diff   = wide[WORD_BITS-1:0];
    assign borrow = wide[WORD_BITS];

endmodule

// ===== rtl/rfdq_ring.sv =====
module rfdq_ring
    import rfdq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WORD_BITS-1:0]     wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WORD_BITS-1:0]     rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    // Write one entry, read one entry into a register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/range_fill_double_ended_queue.sv =====
// Channel   Ports                    Transfer
// -------   ----------------------   --------------------------------------
// command   start, busy, cmd         rising edge with start high, busy low
// result    res_strobe, res          rising edge ending the strobe cycle
//
// Add commands make one ring write per cycle for the stored values, with the
// range tracked by one shared subtract unit; a full store with values still
// pending ends the add with a dropped-values result. Output makes one ring
// read per entry, front to back; its results come back to back. Unknown
// modes give no result. Reset empties the queue at once; the ring itself is
// not cleared. Results cannot be stalled.
module range_fill_double_ended_queue
    import rfdq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    res_strobe,
    output result_t res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DECODE,
        ST_ADD,
        ST_OUT
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [WORD_BITS-1:0] val_reg, val_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic                 stat_strobe_reg, stat_strobe_next;
    result_t              stat_reg, stat_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 rd_last_reg, rd_last_next;

    logic [WORD_BITS-1:0] first_w;
    logic [WORD_BITS-1:0] last_w;
    logic [WORD_BITS-1:0] step_w;
    logic                 step_ok;
    logic                 is_front;
    sub_op_t              sub_op;
    logic [WORD_BITS-1:0] sub_diff;
    logic                 sub_borrow;
    logic                 ring_we;
    logic [AW-1:0]        ring_waddr;
    logic [WORD_BITS-1:0] ring_rdata;
    logic [AW-1:0]        head_dec;

    // Add an offset below DEPTH to a ring index, wrapping once
    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign first_w  = WORD_BITS'(cmd_reg.first_value);
    assign last_w   = WORD_BITS'(cmd_reg.last_value);
    assign step_w   = WORD_BITS'(cmd_reg.step_size);
    assign step_ok  = !step_w[WORD_BITS-1] && (step_w != '0);
    assign is_front = (cmd_reg.mode == MODE_ADD_FRONT);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign sub_op   = (state_reg == ST_ADD) ? OP_STEP : OP_ORDER;

    rfdq_sub_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_sub (
        .op         (sub_op),
        .first_word (first_w),
        .last_word  (last_w),
        .rem_word   (rem_reg),
        .step_word  (step_w),
        .diff       (sub_diff),
        .borrow     (sub_borrow)
    );

    // Write address: below the head for front adds, past the back otherwise
    assign ring_waddr = is_front ? head_dec : wrap_add(head_reg, count_reg);
    assign ring_we    = (state_reg == ST_ADD) && (count_reg != CW'(DEPTH));

    rfdq_ring #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (val_reg),
        .raddr (ptr_reg),
        .rdata (ring_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        val_next         = val_reg;
        rem_next         = rem_reg;
        idx_next         = idx_reg;
        ptr_next         = ptr_reg;
        stat_strobe_next = 1'b0;
        stat_next        = stat_reg;
        rd_pend_next     = 1'b0;
        rd_last_next     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                stat_next  = '0;
                state_next = ST_IDLE;
                unique case (cmd_reg.mode) inside
                    MODE_ADD_BACK, MODE_ADD_FRONT:
                    begin
                        if (!step_ok)
                        begin
                            stat_next.step_error = 1'b1;
                            stat_strobe_next     = 1'b1;
                        end
                        else if (sub_borrow)
                        begin
                            // empty range: nothing to add
                            stat_strobe_next = 1'b1;
                        end
                        else
                        begin
                            rem_next   = sub_diff;
                            val_next   = first_w;
                            state_next = ST_ADD;
                        end
                    end
                    MODE_REMOVE_BACK, MODE_REMOVE_FRONT:
                    begin
                        if (cmd_reg.remove_count >= REMOVE_W'(count_reg))
                        begin
                            count_next = '0;
                        end
                        else
                        begin
                            if (cmd_reg.mode == MODE_REMOVE_FRONT)
                            begin
                                head_next = wrap_add(head_reg, CW'(cmd_reg.remove_count));
                            end
                            count_next = count_reg - CW'(cmd_reg.remove_count);
                        end
                        stat_strobe_next = 1'b1;
                    end
                    MODE_OUTPUT:
                    begin
                        if (count_reg == '0)
                        begin
                            stat_strobe_next = 1'b1;
                        end
                        else
                        begin
                            idx_next   = '0;
                            ptr_next   = head_reg;
                            state_next = ST_OUT;
                        end
                    end
                    default:
                    begin
                        // unknown mode: drop the command silently
                    end
                endcase
                stat_next.last_item  = 1'b1;
                stat_next.is_empty   = (count_next == '0);
                stat_next.fill_level = FILL_W'(count_next);
            end

            ST_ADD:
            begin
                stat_next = '0;
                if (count_reg == CW'(DEPTH))
                begin
                    // store full with values still pending
                    stat_next.dropped_values = 1'b1;
                    stat_strobe_next         = 1'b1;
                    state_next               = ST_IDLE;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    if (is_front)
                    begin
                        head_next = head_dec;
                    end
                    if (sub_borrow)
                    begin
                        stat_strobe_next = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        rem_next = sub_diff;
                        val_next = val_reg + step_w;
                    end
                end
                stat_next.last_item  = 1'b1;
                stat_next.is_empty   = (count_next == '0);
                stat_next.fill_level = FILL_W'(count_next);
            end

            ST_OUT:
            begin
                // issue one ring read per cycle, front to back
                rd_pend_next = 1'b1;
                rd_last_next = (idx_reg == count_reg - CW'(1));
                idx_next     = idx_reg + CW'(1);
                ptr_next     = wrap_add(ptr_reg, CW'(1));
                if (rd_last_next)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
            val_reg         <= '0;
            rem_reg         <= '0;
            idx_reg         <= '0;
            ptr_reg         <= '0;
            stat_strobe_reg <= 1'b0;
            stat_reg        <= '0;
            rd_pend_reg     <= 1'b0;
            rd_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            val_reg         <= val_next;
            rem_reg         <= rem_next;
            idx_reg         <= idx_next;
            ptr_reg         <= ptr_next;
            stat_strobe_reg <= stat_strobe_next;
            stat_reg        <= stat_next;
            rd_pend_reg     <= rd_pend_next;
            rd_last_reg     <= rd_last_next;
        end
    end

    // Result: streamed entry while a read returns, status otherwise
    always_comb
    begin
        if (rd_pend_reg)
        begin
            res                = '0;
            res.item_value     = VAL_W'(ring_rdata);
            res.last_item      = rd_last_reg;
            res.is_empty       = 1'b0;
            res.fill_level     = FILL_W'(count_reg);
        end
        else
        begin
            res = stat_reg;
        end
    end

    assign res_strobe = rd_pend_reg | stat_strobe_reg;
    assign busy       = (state_reg != ST_IDLE);

endmodule
